// ===== hw/rtl/lru_key_value_cache_assert.svh =====
// Assertion macros used by the checker file of the cache.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Checked at every clock edge while reset is released.
`define LKV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define LKV_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/lkv_pkg.sv =====
`timescale 1ns / 1ps

package lkv_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int CAP_W       = 5;
    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic {
        REQ_GET = 1'b0,
        REQ_PUT = 1'b1
    } t_req_type;

    typedef struct packed {
        t_req_type                 req_type;
        logic signed [KEY_W-1:0]   key;
        logic signed [DATA_W-1:0]  value;
    } t_req;

    typedef struct packed {
        logic                      hit;
        logic signed [DATA_W-1:0]  read_value;
    } t_result;

endpackage

// ===== hw/rtl/lkv_slots.sv =====
`timescale 1ns / 1ps

module lkv_slots
    import lkv_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_req             i_req,
    input  logic [CAP_W-1:0] i_capacity,
    output t_result          o_res
);

    localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);

    logic [ENTRIES-1:0]              r_valid;
    logic signed [KEY_W-1:0]         r_key  [ENTRIES];
    logic signed [DATA_W-1:0]        r_data [ENTRIES];
    logic [RW-1:0]                   r_rank [ENTRIES];
    logic [OW-1:0]                   r_occ;

    logic [ENTRIES-1:0]              match;
    logic [ENTRIES-1:0]              free_oh;
    logic [ENTRIES-1:0]              lru_oh;
    logic [ENTRIES-1:0]              tgt;
    logic                            hit;
    logic                            is_put;
    logic                            full;
    logic                            upd;
    logic                            ins;
    logic                            wr_key;
    logic                            wr_data;
    logic [RW-1:0]                   hit_rank;
    logic signed [DATA_W-1:0]        hit_data;
    logic [OW-1:0]                   ref_rank;
    logic [OW-1:0]                   eff_cap;
    logic [OW-1:0]                   occ_m1;

    // Ranks of the valid slots form 0 .. occupancy-1, so the least recent
    // slot is the one whose rank equals occupancy minus one.
    always_comb begin
        is_put = (i_req.req_type == REQ_PUT);

        if (i_capacity == '0) begin
            eff_cap = OW'(1);
        end else if (32'(i_capacity) > 32'(ENTRIES)) begin
            eff_cap = OW'(ENTRIES);
        end else begin
            eff_cap = OW'(i_capacity);
        end

        occ_m1   = r_occ - OW'(1);
        hit_rank = '0;
        hit_data = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]  = r_valid[i] && (r_key[i] == i_req.key);
            lru_oh[i] = r_valid[i] && (OW'(r_rank[i]) == occ_m1);
            if (match[i]) begin
                hit_rank = hit_rank | r_rank[i];
                hit_data = hit_data | r_data[i];
            end
        end

        hit     = |match;
        free_oh = ~r_valid & (r_valid + ENTRIES'(1));
        full    = (r_occ >= eff_cap);

        tgt      = '0;
        ref_rank = '0;
        upd      = 1'b0;
        ins      = 1'b0;
        wr_key   = 1'b0;
        wr_data  = 1'b0;
        priority if (hit) begin
            tgt      = match;
            ref_rank = OW'(hit_rank);
            upd      = 1'b1;
            wr_data  = is_put;
        end else if (is_put && !full) begin
            // Every valid rank is below occupancy, so all of them age.
            tgt      = free_oh;
            ref_rank = r_occ;
            upd      = 1'b1;
            ins      = 1'b1;
            wr_key   = 1'b1;
            wr_data  = 1'b1;
        end else if (is_put) begin
            tgt      = lru_oh;
            ref_rank = occ_m1;
            upd      = 1'b1;
            wr_key   = 1'b1;
            wr_data  = 1'b1;
        end else begin
            upd      = 1'b0;
        end

        o_res.hit        = hit;
        o_res.read_value = (hit && !is_put) ? hit_data : '1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_en && upd) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (tgt[i]) begin
                    r_rank[i] <= '0;
                end else if (r_valid[i] && (OW'(r_rank[i]) < ref_rank)) begin
                    r_rank[i] <= r_rank[i] + RW'(1);
                end
            end
            if (ins) begin
                r_valid <= r_valid | tgt;
                r_occ   <= r_occ + OW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (tgt[i] && wr_key) begin
                    r_key[i] <= i_req.key;
                end
                if (tgt[i] && wr_data) begin
                    r_data[i] <= i_req.value;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/lru_key_value_cache.sv =====
`timescale 1ns / 1ps

// Fully associative key-value cache with least-recently-used replacement.
// Requests enter on the input channel (i_in_valid / o_in_stall) with a
// request type (get or put), a key and a value. Every request gives one
// item on the output channel (o_out_valid / i_out_stall): a hit flag and
// the stored value on a get hit, all ones otherwise.
// A request is held in an input register and looked up against all slots
// in parallel once the output register is free or being drained; its
// result is loaded into the output register at the same edge that updates
// the slots, which raises o_out_valid. One item per cycle is sustained
// while the receiver does not stall, set by the combinational compare
// and recency update over all slots.
// When the receiver stalls, the result holds, one more request may wait in
// the input register, and then o_in_stall rises until the output drains.
// The capacity register is written through i_cfg_wr_en / i_cfg_wr_data,
// which the user must do only while no request is in flight; the block
// itself does not enforce it. It resets to 16. Synchronous reset empties
// the cache (all slots invalid, occupancy zero) and drops any item in flight.
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CAP_W-1:0]         i_cfg_wr_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_in_req_type,
    input  logic signed [KEY_W-1:0]  i_in_key,
    input  logic signed [DATA_W-1:0] i_in_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_out_hit,
    output logic signed [DATA_W-1:0] o_out_read_value
);

    logic [CAP_W-1:0] r_capacity;
    logic             r_in_valid;
    t_req             r_req;
    logic             r_out_valid;
    t_result          r_res;

    logic             accept;
    logic             process;
    t_result          res;

    assign process    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !process;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_capacity <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.req_type <= t_req_type'(i_in_req_type);
            r_req.key      <= i_in_key;
            r_req.value    <= i_in_value;
        end
    end

    lkv_slots #(
        .ENTRIES (ENTRIES)
    ) u_slots (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (process),
        .i_req      (r_req),
        .i_capacity (r_capacity),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_res <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_hit        = r_res.hit;
    assign o_out_read_value = r_res.read_value;

endmodule

// ===== hw/rtl/lkv_checker.sv =====
`timescale 1ns / 1ps

`include "lru_key_value_cache_assert.svh"

module lkv_checker
    import lkv_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic                     o_out_hit,
    input logic signed [DATA_W-1:0] o_out_read_value
);

    // A miss never carries a stored value.
    `LKV_ASSERT(a_miss_reads_ones, i_clk, i_rst_n, o_out_valid && !o_out_hit |-> o_out_read_value == '1, "miss result is not all ones")

    // The input side only backs up when the output side is held.
    `LKV_ASSERT(a_stall_from_output, i_clk, i_rst_n, o_in_stall |-> o_out_valid && i_out_stall, "input stalled while output is free")

    // A held result keeps its contents.
    `LKV_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_hit) && $stable(o_out_read_value), "stalled result changed")

    // Reset drops every item in flight.
    `LKV_ASSERT_ALWAYS(a_reset_flush, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "item survived reset")

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);

// ===== tb/tb_lru_key_value_cache.sv =====
`timescale 1ns / 1ps

module tb_lru_key_value_cache;
    import lkv_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASES      = 10;
    localparam int POOL_SIZE   = 20;

    class lru_scoreboard;
        logic [CAP_W-1:0]  capacity;
        bit                slot_used[ENTRIES_DEF];
        logic [KEY_W-1:0]  slot_key[ENTRIES_DEF];
        logic [DATA_W-1:0] slot_data[ENTRIES_DEF];
        int unsigned       slot_age[ENTRIES_DEF];
        int unsigned       occupied;
        t_result           expected_results[$];
        int                mismatches;

        function new();
            capacity = CAP_RESET;
            occupied = 0;
            mismatches = 0;
            foreach (slot_used[i]) begin
                slot_used[i] = 1'b0;
                slot_age[i] = 0;
            end
        endfunction

        function void set_capacity(logic [CAP_W-1:0] c);
            capacity = c;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Slots younger than s age by one and s becomes the most recent.
        function void promote(int s);
            int unsigned r;
            r = slot_age[s];
            for (int i = 0; i < ENTRIES_DEF; i++) begin
                if (slot_used[i] && i != s && slot_age[i] < r) begin
                    slot_age[i]++;
                end
            end
            slot_age[s] = 0;
        endfunction

        function void note_request(t_req_type kind, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
            int          found;
            int          fill;
            int          oldest;
            int unsigned room;
            t_result     res;
            found = -1;
            for (int i = 0; i < ENTRIES_DEF; i++) begin
                if (found < 0 && slot_used[i] && slot_key[i] == k) begin
                    found = i;
                end
            end
            res.hit = (found >= 0);
            res.read_value = '1;
            room = (capacity == 0) ? 1 : ((capacity > ENTRIES_DEF) ? ENTRIES_DEF : capacity);
            if (kind == REQ_GET) begin
                if (found >= 0) begin
                    res.read_value = slot_data[found];
                    promote(found);
                end
            end else if (found >= 0) begin
                slot_data[found] = v;
                promote(found);
            end else if (occupied < room) begin
                fill = -1;
                for (int i = 0; i < ENTRIES_DEF; i++) begin
                    if (fill < 0 && !slot_used[i]) begin
                        fill = i;
                    end
                end
                if (fill >= 0) begin
                    for (int i = 0; i < ENTRIES_DEF; i++) begin
                        if (slot_used[i]) begin
                            slot_age[i]++;
                        end
                    end
                    slot_used[fill] = 1'b1;
                    slot_key[fill] = k;
                    slot_data[fill] = v;
                    slot_age[fill] = 0;
                    occupied++;
                end
            end else begin
                oldest = -1;
                for (int i = 0; i < ENTRIES_DEF; i++) begin
                    if (slot_used[i] && (oldest < 0 || slot_age[i] > slot_age[oldest])) begin
                        oldest = i;
                    end
                end
                if (oldest >= 0) begin
                    slot_key[oldest] = k;
                    slot_data[oldest] = v;
                    promote(oldest);
                end
            end
            expected_results.push_back(res);
        endfunction

        function void check_result(logic hit, logic [DATA_W-1:0] read_value);
            t_result want;
            if (expected_results.size() == 0) begin
                $error("Result item with no request pending: hit %0b read_value %h",
                       hit, read_value);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (hit !== want.hit) begin
                $error("hit: expected %0b, actual %0b", want.hit, hit);
                mismatches++;
            end
            if (read_value !== want.read_value) begin
                $error("read_value: expected %h, actual %h", want.read_value, read_value);
                mismatches++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]         i_cfg_wr_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic                     i_in_req_type = 1'b0;
    logic signed [KEY_W-1:0]  i_in_key = '0;
    logic signed [DATA_W-1:0] i_in_value = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_out_hit;
    logic signed [DATA_W-1:0] o_out_read_value;

    lru_scoreboard board;
    int unsigned   cycle_count = 0;
    int unsigned   hold_trigger = 0;
    int unsigned   hold_seen = 0;
    int unsigned   hold_left = 0;
    logic [5:0]    stall_tick = '0;
    logic [1:0]    stall_mode = '0;
    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    int phase_capacity[PHASES] = '{16, 3, 0, 31, 1, 7, 17, 12, 16, 2};
    int phase_items[PHASES]    = '{70, 50, 40, 60, 40, 60, 50, 60, 60, 60};
    bit phase_gaps[PHASES]     = '{1, 1, 0, 1, 1, 0, 1, 1, 1, 1};
    int phase_hold_at[PHASES]  = '{0, 0, 8, 0, 0, 0, 0, 20, 0, 0};

    lru_key_value_cache i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_req_type    (i_in_req_type),
        .i_in_key         (i_in_key),
        .i_in_value       (i_in_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_hit        (o_out_hit),
        .o_out_read_value (o_out_read_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The receiver checks each accepted item, then picks its next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_result(o_out_hit, o_out_read_value);
        end
        stall_tick <= stall_tick + 6'd1;
        if (stall_tick == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
        end
        if (hold_trigger != hold_seen) begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                2'd0: i_out_stall <= 1'b0;
                2'd1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2'd2: i_out_stall <= ($urandom_range(0, 1) == 0);
                default: i_out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic send_item(input t_req_type kind, input logic [31:0] k, input logic [31:0] v);
        i_in_valid <= 1'b1;
        i_in_req_type <= kind;
        i_in_key <= k;
        i_in_value <= v;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(kind, k, v);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= c;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        board.set_capacity(c);
    endtask

    task automatic run_random_phase(input int n_items, input bit gaps_on, input int hold_at);
        int          sent;
        int          burst;
        int          pick;
        logic [31:0] k;
        logic [31:0] v;
        t_req_type   kind;
        sent = 0;
        repeat (5) key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
        while (sent < n_items) begin
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst && sent < n_items; j++) begin
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                end else if (pick < 95) begin
                    k = $urandom;
                end else begin
                    k = corner_word();
                end
                v = ($urandom_range(0, 19) == 0) ? corner_word() : $urandom;
                kind = ($urandom_range(0, 1) == 1) ? REQ_PUT : REQ_GET;
                send_item(kind, k, v);
                sent++;
                if (hold_at != 0 && sent == hold_at) begin
                    hold_trigger <= hold_trigger + 1;
                end
            end
            if (gaps_on && $urandom_range(0, 3) != 0) begin
                pause_sender($urandom_range(1, 6));
            end
        end
        drain_results();
    endtask

    initial begin
        board = new();
        foreach (key_pool[i]) begin
            key_pool[i] = $urandom;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A capacity of two makes eviction order visible in a few items.
        write_capacity(5'd2);
        send_item(REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(REQ_GET, 32'h8000_0000, 32'h0000_0000);
        send_item(REQ_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(REQ_GET, 32'h7FFF_FFFF, 32'h1234_5678);
        send_item(REQ_GET, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
        send_item(REQ_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(REQ_GET, 32'h8000_0000, 32'h5555_5555);
        send_item(REQ_GET, 32'h0000_0000, 32'h0000_0000);
        send_item(REQ_PUT, 32'h0000_0000, 32'h5555_5555);
        send_item(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(REQ_GET, 32'h0000_0000, 32'hAAAA_AAAA);
        send_item(REQ_PUT, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
        send_item(REQ_PUT, 32'h5555_5555, 32'h5555_5555);
        send_item(REQ_GET, 32'h0000_0000, 32'h0000_0000);
        send_item(REQ_GET, 32'hAAAA_AAAA, 32'h0000_0000);
        send_item(REQ_GET, 32'h5555_5555, 32'h0000_0000);
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            write_capacity(CAP_W'(phase_capacity[p]));
            run_random_phase(phase_items[p], phase_gaps[p], phase_hold_at[p]);
        end

        repeat (10) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/lkv_pkg.sv
hw/rtl/lkv_slots.sv
hw/rtl/lru_key_value_cache.sv
hw/rtl/lkv_checker.sv
tb/tb_lru_key_value_cache.sv
